FILE: rtl/core/vds2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds2_pkg - shared types and constants for the 2x volume downsampler
// Field widths, register codes, reduction modes, the classification flags
// passed from the front end to the back end, and the back end state type.
// ----------------------------------------------------------------------------
package vds2_pkg;

  // Fixed field widths
  localparam int SIZE_W  = 9;
  localparam int MODE_W  = 2;
  localparam int VOXEL_W = 8;
  localparam int ACC_W   = 11;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 2;

  // Divider iterates once per accumulator bit
  localparam int DIV_STEPS = ACC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Defaults
  localparam int DEFAULT_MAX_DIM = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  // Reduction modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PICK = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_MEAN = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_MODE   = 2'd3
  } reg_index_t;

  // Classification of one voxel within its cell
  typedef struct packed {
    logic  first;
    logic  last;
    logic  fin;
    mode_t mode;
  } flags_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

FILE: rtl/core/vds2_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds2_in_if - input voxel channel
// Valid/ready channel carrying one 8-bit voxel per transaction.
// ----------------------------------------------------------------------------
interface vds2_in_if;
  logic                         valid;
  logic                         ready;
  logic [vds2_pkg::VOXEL_W-1:0] voxel;

  modport source (output valid, output voxel, input ready);
  modport sink   (input valid, input voxel, output ready);
endinterface

FILE: rtl/core/vds2_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds2_out_if - downsampled result channel
// Valid/ready channel carrying one reduced voxel and an end-of-volume flag.
// ----------------------------------------------------------------------------
interface vds2_out_if;
  logic                         valid;
  logic                         ready;
  logic [vds2_pkg::VOXEL_W-1:0] value;
  logic                         final_res;

  modport source (output valid, output value, output final_res, input ready);
  modport sink   (input valid, input value, input final_res, output ready);
endinterface

FILE: rtl/core/vds2_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds2_front - configuration and voxel classification
// Holds the size and mode registers and the raster position. Each accepted
// voxel is tagged with its cell address and first/last/final flags and
// pushed into the queue towards the back end.
// ----------------------------------------------------------------------------
module vds2_front #(
  parameter int  MAX_DIM = vds2_pkg::DEFAULT_MAX_DIM,
  localparam int CELLS   = (MAX_DIM + 1) / 2,
  localparam int DEPTH   = CELLS * CELLS,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [vds2_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vds2_pkg::SIZE_W-1:0]  cfg_data,
  vds2_in_if.sink                      in_ch,
  input  logic                         full,
  output logic                         push,
  output logic [vds2_pkg::VOXEL_W-1:0] push_voxel,
  output logic [ADDR_W-1:0]            push_addr,
  output vds2_pkg::flags_t             push_flags
);

  localparam int POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EFF_W  = POS_W + 1;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [vds2_pkg::SIZE_W-1:0] size_x;
  logic [vds2_pkg::SIZE_W-1:0] size_y;
  logic [vds2_pkg::SIZE_W-1:0] size_z;
  vds2_pkg::mode_t             mode;
  logic [POS_W-1:0]            pos_x;
  logic [POS_W-1:0]            pos_y;
  logic [POS_W-1:0]            pos_z;
  logic [EFF_W-1:0]            eff_x;
  logic [EFF_W-1:0]            eff_y;
  logic [EFF_W-1:0]            eff_z;
  logic                        x_end;
  logic                        y_end;
  logic                        z_end;
  logic [CELL_W-1:0]           row;
  logic [CELL_W-1:0]           col;
  logic                        accept;

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [EFF_W-1:0] eff_size(input logic [vds2_pkg::SIZE_W-1:0] s);
    logic [EFF_W-1:0] r;
    if (s == '0) begin
      r = EFF_W'(1);
    end else if (32'(s) > 32'(MAX_DIM)) begin
      r = EFF_W'(MAX_DIM);
    end else begin
      r = EFF_W'(s);
    end
    return r;
  endfunction

  assign eff_x = eff_size(size_x);
  assign eff_y = eff_size(size_y);
  assign eff_z = eff_size(size_z);

  // Row, plane and volume ends
  assign x_end = ({1'b0, pos_x} + EFF_W'(1)) >= eff_x;
  assign y_end = ({1'b0, pos_y} + EFF_W'(1)) >= eff_y;
  assign z_end = ({1'b0, pos_z} + EFF_W'(1)) >= eff_z;

  // Handshake: take a voxel whenever the queue has room
  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;
  assign push        = accept;
  assign push_voxel  = in_ch.voxel;

  // Cell address within a plane pair
  assign row       = CELL_W'(pos_y >> 1);
  assign col       = CELL_W'(pos_x >> 1);
  assign push_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(CELLS) + ADDR_W'(col));

  // Classify the voxel within its cell
  always_comb begin
    push_flags.first = !pos_x[0] && !pos_y[0] && !pos_z[0];
    push_flags.last  = (pos_x[0] || x_end) && (pos_y[0] || y_end) && (pos_z[0] || z_end);
    push_flags.fin   = x_end && y_end && z_end;
    push_flags.mode  = mode;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= vds2_pkg::SIZE_RESET;
      size_y <= vds2_pkg::SIZE_RESET;
      size_z <= vds2_pkg::SIZE_RESET;
      mode   <= vds2_pkg::MODE_MEAN;
    end else if (cfg_we) begin
      case (vds2_pkg::reg_index_t'(cfg_index))
        vds2_pkg::REG_SIZE_X: size_x <= cfg_data;
        vds2_pkg::REG_SIZE_Y: size_y <= cfg_data;
        vds2_pkg::REG_SIZE_Z: size_z <= cfg_data;
        vds2_pkg::REG_MODE:   mode   <= vds2_pkg::mode_t'(cfg_data[vds2_pkg::MODE_W-1:0]);
        default:              mode   <= mode;
      endcase
    end
  end

  // Raster position: restart on any register write, advance per transaction
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (x_end) begin
        pos_x <= '0;
        if (y_end) begin
          pos_y <= '0;
          pos_z <= z_end ? '0 : pos_z + POS_W'(1);
        end else begin
          pos_y <= pos_y + POS_W'(1);
        end
      end else begin
        pos_x <= pos_x + POS_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/vds2_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds2_queue - short FIFO between front and back ends
// Register-based ring buffer; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module vds2_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = vds2_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/vds2_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds2_back - cell accumulation, mean divider and result register
// Read-modify-write of the per-cell store for each queued voxel; on a
// cell's last voxel forms the result (bit-serial divide for the mean) and
// loads it into the output register.
// ----------------------------------------------------------------------------
module vds2_back #(
  parameter int  MAX_DIM = vds2_pkg::DEFAULT_MAX_DIM,
  localparam int CELLS   = (MAX_DIM + 1) / 2,
  localparam int DEPTH   = CELLS * CELLS,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  output logic                         pop,
  input  logic [vds2_pkg::VOXEL_W-1:0] pop_voxel,
  input  logic [ADDR_W-1:0]            pop_addr,
  input  vds2_pkg::flags_t             pop_flags,
  vds2_out_if.source                   out_ch
);

  localparam int ACC_W  = vds2_pkg::ACC_W;
  localparam int CNT_W  = vds2_pkg::CNT_W;
  localparam int WORD_W = ACC_W + CNT_W;

  vds2_pkg::back_state_t       state;
  vds2_pkg::back_state_t       state_next;

  logic [WORD_W-1:0]           store [DEPTH];
  logic [WORD_W-1:0]           rd_word;
  logic [ACC_W-1:0]            rd_acc;
  logic [CNT_W-1:0]            rd_cnt;

  logic [vds2_pkg::VOXEL_W-1:0] op_voxel;
  logic [ADDR_W-1:0]            op_addr;
  vds2_pkg::flags_t             op_flags;

  logic [ACC_W-1:0]            new_acc;
  logic [CNT_W-1:0]            new_cnt;
  logic [ACC_W-1:0]            vox_ext;

  logic [ACC_W-1:0]            div_quo;
  logic [CNT_W-1:0]            div_rem;
  logic [CNT_W-1:0]            div_den;
  logic [vds2_pkg::STEP_W-1:0] div_step;
  logic [CNT_W:0]              trial;
  logic                        trial_ge;
  logic [ACC_W-1:0]            quo_next;
  logic [CNT_W-1:0]            rem_next;
  logic                        div_done;

  logic [vds2_pkg::VOXEL_W-1:0] res_value;
  logic                         res_fin;

  logic                        mem_we;
  logic                        div_load;
  logic                        res_load;
  logic                        out_load;
  logic                        out_valid;
  logic                        is_mean;

  assign rd_acc  = rd_word[WORD_W-1:CNT_W];
  assign rd_cnt  = rd_word[CNT_W-1:0];
  assign vox_ext = ACC_W'(op_voxel);
  assign is_mean = (op_flags.mode == vds2_pkg::MODE_MEAN);

  // Combine the voxel with the stored partial result
  always_comb begin
    if (op_flags.first) begin
      new_acc = vox_ext;
      new_cnt = CNT_W'(1);
    end else begin
      case (op_flags.mode)
        vds2_pkg::MODE_MAX:  new_acc = (vox_ext > rd_acc) ? vox_ext : rd_acc;
        vds2_pkg::MODE_MIN:  new_acc = (vox_ext < rd_acc) ? vox_ext : rd_acc;
        vds2_pkg::MODE_MEAN: new_acc = rd_acc + vox_ext;
        default:             new_acc = rd_acc;
      endcase
      new_cnt = rd_cnt + CNT_W'(1);
    end
  end

  // One restoring divide step
  assign trial    = {div_rem, div_quo[ACC_W-1]};
  assign trial_ge = (trial >= {1'b0, div_den});
  assign rem_next = trial_ge ? CNT_W'(trial - {1'b0, div_den}) : trial[CNT_W-1:0];
  assign quo_next = {div_quo[ACC_W-2:0], trial_ge};
  assign div_done = (div_step == vds2_pkg::STEP_W'(vds2_pkg::DIV_STEPS - 1));

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      vds2_pkg::BK_IDLE: begin
        if (!empty) begin
          state_next = vds2_pkg::BK_CALC;
        end
      end
      vds2_pkg::BK_CALC: begin
        if (!op_flags.last) begin
          state_next = vds2_pkg::BK_IDLE;
        end else if (is_mean && new_cnt != '0) begin
          state_next = vds2_pkg::BK_DIV;
        end else begin
          state_next = vds2_pkg::BK_EMIT;
        end
      end
      vds2_pkg::BK_DIV: begin
        if (div_done) begin
          state_next = vds2_pkg::BK_EMIT;
        end
      end
      vds2_pkg::BK_EMIT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = vds2_pkg::BK_IDLE;
        end
      end
      default: state_next = vds2_pkg::BK_IDLE;
    endcase
  end

  // Sequencer: strobes
  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    div_load = 1'b0;
    res_load = 1'b0;
    out_load = 1'b0;
    case (state)
      vds2_pkg::BK_IDLE: begin
        pop = !empty;
      end
      vds2_pkg::BK_CALC: begin
        mem_we   = 1'b1;
        div_load = op_flags.last && is_mean && new_cnt != '0;
        res_load = op_flags.last && !(is_mean && new_cnt != '0);
      end
      vds2_pkg::BK_EMIT: begin
        out_load = !out_valid || out_ch.ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vds2_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cell store: write back, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[op_addr] <= {new_acc, new_cnt};
    end
    if (pop) begin
      rd_word <= store[pop_addr];
    end
  end

  // Hold the voxel being worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      op_voxel <= pop_voxel;
      op_addr  <= pop_addr;
      op_flags <= pop_flags;
    end
  end

  // Divider and result holding
  always_ff @(posedge clk) begin
    if (div_load) begin
      div_quo  <= new_acc;
      div_rem  <= '0;
      div_den  <= new_cnt;
      div_step <= '0;
      res_fin  <= op_flags.fin;
    end else if (state == vds2_pkg::BK_DIV) begin
      div_quo  <= quo_next;
      div_rem  <= rem_next;
      div_step <= div_step + vds2_pkg::STEP_W'(1);
      if (div_done) begin
        res_value <= quo_next[vds2_pkg::VOXEL_W-1:0];
      end
    end else if (res_load) begin
      // mean with empty count gives zero
      res_value <= is_mean ? '0 : new_acc[vds2_pkg::VOXEL_W-1:0];
      res_fin   <= op_flags.fin;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.value     <= res_value;
      out_ch.final_res <= res_fin;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

FILE: rtl/core/volume_downsample_2x_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_downsample_2x_unit - 2x2x2 voxel downsampler (pick/max/min/mean)
// Streams 8-bit voxels in raster order and emits one reduced voxel per cell.
//
//   channel   dir  payload                       transaction on
//   in_ch     in   voxel[7:0]                    valid && ready
//   out_ch    out  value[7:0], final_res         valid && ready
//   cfg       in   cfg_index[1:0], cfg_data[8:0] cfg_we
//
// A voxel that does not close its cell takes the back end through IDLE
// (store read) and CALC (combine and write back on one port). A closing
// voxel goes on to EMIT in pick, max and min, and through DIV to EMIT in
// mean, where an 11-step bit-serial divider forms the quotient. Reset is
// synchronous and clears control state only; the cell store has no clearing
// pass, as a cell's first voxel overwrites its entry, ignoring the old one.
// A two-entry queue lets the front end take voxels while the back end works,
// and the output register holds a result while the sink stalls.
// ----------------------------------------------------------------------------
module volume_downsample_2x_unit #(
  parameter int MAX_DIM = vds2_pkg::DEFAULT_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [vds2_pkg::IDX_W-1:0]  cfg_index,
  input  logic [vds2_pkg::SIZE_W-1:0] cfg_data,
  vds2_in_if.sink                     in_ch,
  vds2_out_if.source                  out_ch
);

  localparam int CELLS  = (MAX_DIM + 1) / 2;
  localparam int DEPTH  = CELLS * CELLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FLG_W  = $bits(vds2_pkg::flags_t);
  localparam int Q_W    = vds2_pkg::VOXEL_W + ADDR_W + FLG_W;

  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic [vds2_pkg::VOXEL_W-1:0] push_voxel;
  logic [ADDR_W-1:0]            push_addr;
  vds2_pkg::flags_t             push_flags;
  logic [Q_W-1:0]               q_rd;
  logic [vds2_pkg::VOXEL_W-1:0] pop_voxel;
  logic [ADDR_W-1:0]            pop_addr;
  vds2_pkg::flags_t             pop_flags;

  // Front end: configuration, position, classification
  vds2_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .full       (q_full),
    .push       (q_push),
    .push_voxel (push_voxel),
    .push_addr  (push_addr),
    .push_flags (push_flags)
  );

  // Queue between the two ends
  vds2_queue #(
    .WIDTH (Q_W),
    .DEPTH (vds2_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_voxel, push_addr, push_flags}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  assign pop_voxel = q_rd[Q_W-1 -: vds2_pkg::VOXEL_W];
  assign pop_addr  = q_rd[FLG_W +: ADDR_W];
  assign pop_flags = vds2_pkg::flags_t'(q_rd[FLG_W-1:0]);

  // Back end: cell store, divider, output register
  vds2_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .pop       (q_pop),
    .pop_voxel (pop_voxel),
    .pop_addr  (pop_addr),
    .pop_flags (pop_flags),
    .out_ch    (out_ch)
  );

  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A lone push leaves the queue occupied
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> !q_empty)
    else $error("queue empty after push");

  // Any register write restarts at the first voxel of a cell
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (q_push |-> push_flags.first))
    else $error("voxel after register write not at volume origin");

  // The final voxel of the volume always closes a cell
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (q_push && push_flags.fin) |-> push_flags.last)
    else $error("volume end on a voxel that does not close its cell");

endmodule
